/* hdl/assert_macros.svh */
// Assertion macros used by the port checker of this block.
// Needs nothing else; each macro expands to one labeled concurrent assertion.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define BDC_ASSERT_IMPL(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define BDC_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* hdl/bdc_pkg.sv */
// Shared types, constants and register helpers of the 3x3 dilation cascade.
// Used by the top level and by the port checker; depends on nothing.
`default_nettype none

package bdc_pkg;

  localparam int MAX_WIDTH  = 1024;
  localparam int PASSES     = 7;
  localparam int COL_W      = $clog2(MAX_WIDTH);
  localparam int ROW_W      = 16;
  localparam int WIDTH_W    = 11;
  localparam int PIX_W      = 8;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 16;

  localparam int MIN_WIDTH  = 3;
  localparam int MIN_HEIGHT = 3;
  localparam int WIDTH_RST  = 640;
  localparam int HEIGHT_RST = 480;

  localparam logic [PIX_W-1:0] FG_LEVEL   = 8'hFF;
  localparam logic             KIND_PIXEL = 1'b0;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_IMAGE_WIDTH  = 1'b0,
    REG_IMAGE_HEIGHT = 1'b1
  } cfg_reg_t;

  typedef struct packed {
    logic             kind;
    logic [PIX_W-1:0] pixel_in;
  } in_data_t;

  typedef struct packed {
    logic [PIX_W-1:0] pixel_out;
    logic             frame_end;
  } out_data_t;

  // last column index for a raw width, width saturated to [MIN_WIDTH, MAX_WIDTH]
  function automatic logic [COL_W-1:0] width_last(input logic [WIDTH_W-1:0] raw);
    logic [WIDTH_W-1:0] w;
    w = raw;
    if (w < WIDTH_W'(MIN_WIDTH)) begin
      w = WIDTH_W'(MIN_WIDTH);
    end else if (w > WIDTH_W'(MAX_WIDTH)) begin
      w = WIDTH_W'(MAX_WIDTH);
    end
    return COL_W'(w - 1'b1);
  endfunction

  // last row index for a raw height, height saturated to at least MIN_HEIGHT
  function automatic logic [ROW_W-1:0] height_last(input logic [ROW_W-1:0] raw);
    logic [ROW_W-1:0] h;
    h = raw;
    if (h < ROW_W'(MIN_HEIGHT)) begin
      h = ROW_W'(MIN_HEIGHT);
    end
    return ROW_W'(h - 1'b1);
  endfunction

endpackage

`default_nettype wire

/* hdl/binary_dilation_3x3_cascade_unit.sv */
// Top level of the seven-pass binary 3x3 dilation cascade.
// Depends on bdc_pkg; holds the shared line memory and all stage windows.
//
// Usage:
//  - in channel (valid/ready): one word per pixel in raster order, kind = pixel;
//    after the frame's last pixel, further words (any kind) are drain ticks.
//    A drain word before the last pixel is taken and dropped.
//  - out channel (valid/ready): one word per output pixel, 0 or 255, with
//    frame_end on the frame's last pixel; the frame position then restarts.
//  - cfg channel: index 0 = image width (saturated to 3..1024),
//    index 1 = image height (at least 3). A write restarts the frame position.
//    Always ready outside reset.
//  - Throughput: one word per clock while out is not stalled. A result is
//    registered at the edge that takes its word; pixel p leaves with the word
//    that arrives 7*(width+1) words after it, set by the two-row line memory
//    and window of each of the seven passes.
//  - Reset: 640x480, frame position zero. The line memory is not cleared;
//    taps outside the current frame are masked by position.
//  - Stall: a waiting result holds; in_ready drops while out_valid is high
//    and out_ready is low, and rises again in the cycle out_ready returns.
`default_nettype none

module binary_dilation_3x3_cascade_unit import bdc_pkg::*; (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_valid,
  output logic                       in_ready,
  input  wire in_data_t              in_data,
  output logic                       out_valid,
  input  wire logic                  out_ready,
  output out_data_t                  out_data,
  input  wire logic                  cfg_valid,
  output logic                       cfg_ready,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int NPOS = PASSES + 1;
  localparam int LB_W = 2 * PASSES;

  logic [COL_W-1:0] w_m1_r;
  logic [ROW_W-1:0] h_m1_r;

  // raster position of each stage's input (index PASSES = final output)
  logic [COL_W-1:0] x_r   [NPOS];
  logic [COL_W-1:0] x_nxt [NPOS];
  logic [ROW_W-1:0] y_r   [NPOS];
  logic [ROW_W-1:0] y_nxt [NPOS];
  logic [PASSES:1]  started_r, started_nxt;
  logic [NPOS-1:0]  done_r, done_nxt;

  logic [COL_W-1:0] ptr_r, ptr_nxt;
  logic [LB_W-1:0]  lb_mem [MAX_WIDTH];
  logic [LB_W-1:0]  lb_rd_r;
  logic [LB_W-1:0]  lb_wr;

  // previous two taps of each window row, bit 0 = one tick back
  logic [1:0] row0_r [PASSES];
  logic [1:0] row1_r [PASSES];
  logic [1:0] row2_r [PASSES];

  logic      out_valid_r;
  out_data_t out_data_r;

  logic cfg_we, accept, tick, frame_last;
  logic [NPOS-1:0] active, x0, xl, y0, yl;
  logic [PASSES:1] start_hit;
  logic [PASSES:0] v;
  logic [PASSES-1:0] m;

  assign cfg_ready = rst_n;
  assign cfg_we    = cfg_valid & rst_n;
  assign in_ready  = rst_n & (!out_valid_r | out_ready);
  assign accept    = in_valid & in_ready;
  assign tick      = accept & ((in_data.kind == KIND_PIXEL) | done_r[0]);

  always_comb begin
    logic [2:0] r0, r1, r2, cmask;
    for (int k = 0; k < NPOS; k++) begin
      x0[k] = (x_r[k] == '0);
      xl[k] = (x_r[k] == w_m1_r);
      y0[k] = (y_r[k] == '0);
      yl[k] = (y_r[k] == h_m1_r);
    end
    active[0] = !done_r[0];
    for (int k = 1; k < NPOS; k++) begin
      start_hit[k] = active[k-1] & (x_r[k-1] == COL_W'(1)) & (y_r[k-1] == ROW_W'(1));
      active[k]    = (started_r[k] | start_hit[k]) & !done_r[k];
    end
    v[0] = (in_data.kind == KIND_PIXEL) & !done_r[0] & (in_data.pixel_in == FG_LEVEL);
    for (int s = 0; s < PASSES; s++) begin
      m[s]  = v[s] & active[s] & !x0[s] & !xl[s] & !y0[s] & !yl[s];
      r0    = {m[s], row0_r[s][0], row0_r[s][1]};
      r1    = {lb_rd_r[2*s], row1_r[s][0], row1_r[s][1]};
      r2    = {lb_rd_r[2*s+1], row2_r[s][0], row2_r[s][1]};
      cmask = {!xl[s+1], 1'b1, !x0[s+1]};
      v[s+1] = active[s+1] & ((|(r0 & cmask & {3{!yl[s+1]}})) | (|(r1 & cmask)) |
                              (|(r2 & cmask & {3{!y0[s+1]}})));
      lb_wr[2*s +: 2] = {lb_rd_r[2*s], m[s]};
    end
  end

  assign frame_last = active[PASSES] & xl[PASSES] & yl[PASSES];

  always_comb begin
    ptr_nxt     = ptr_r;
    started_nxt = started_r;
    done_nxt    = done_r;
    for (int k = 0; k < NPOS; k++) begin
      x_nxt[k] = x_r[k];
      y_nxt[k] = y_r[k];
    end
    if (cfg_we) begin
      ptr_nxt     = '0;
      started_nxt = '0;
      done_nxt    = '0;
      for (int k = 0; k < NPOS; k++) begin
        x_nxt[k] = '0;
        y_nxt[k] = '0;
      end
    end else if (tick) begin
      ptr_nxt = (ptr_r == w_m1_r) ? '0 : COL_W'(ptr_r + 1'b1);
      if (frame_last) begin
        started_nxt = '0;
        done_nxt    = '0;
        for (int k = 0; k < NPOS; k++) begin
          x_nxt[k] = '0;
          y_nxt[k] = '0;
        end
      end else begin
        started_nxt = started_r | start_hit;
        for (int k = 0; k < NPOS; k++) begin
          if (active[k]) begin
            if (xl[k]) begin
              x_nxt[k] = '0;
              if (yl[k]) begin
                done_nxt[k] = 1'b1;
              end else begin
                y_nxt[k] = ROW_W'(y_r[k] + 1'b1);
              end
            end else begin
              x_nxt[k] = COL_W'(x_r[k] + 1'b1);
            end
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      w_m1_r    <= width_last(WIDTH_W'(WIDTH_RST));
      h_m1_r    <= height_last(ROW_W'(HEIGHT_RST));
      ptr_r     <= '0;
      started_r <= '0;
      done_r    <= '0;
      for (int k = 0; k < NPOS; k++) begin
        x_r[k] <= '0;
        y_r[k] <= '0;
      end
    end else begin
      if (cfg_we) begin
        unique case (cfg_reg_t'(cfg_index))
          REG_IMAGE_WIDTH:  w_m1_r <= width_last(cfg_data[WIDTH_W-1:0]);
          REG_IMAGE_HEIGHT: h_m1_r <= height_last(cfg_data[ROW_W-1:0]);
          default: ;
        endcase
      end
      ptr_r     <= ptr_nxt;
      started_r <= started_nxt;
      done_r    <= done_nxt;
      for (int k = 0; k < NPOS; k++) begin
        x_r[k] <= x_nxt[k];
        y_r[k] <= y_nxt[k];
      end
    end
  end

  // line memory: both delayed rows of every pass, one word per column slot
  always_ff @(posedge clk) begin
    if (tick) begin
      lb_mem[ptr_r] <= lb_wr;
    end
    lb_rd_r <= lb_mem[ptr_nxt];
  end

  always_ff @(posedge clk) begin
    if (tick) begin
      for (int s = 0; s < PASSES; s++) begin
        row0_r[s] <= {row0_r[s][0], m[s]};
        row1_r[s] <= {row1_r[s][0], lb_rd_r[2*s]};
        row2_r[s] <= {row2_r[s][0], lb_rd_r[2*s+1]};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (tick && active[PASSES]) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
    if (tick && active[PASSES]) begin
      out_data_r.pixel_out <= v[PASSES] ? FG_LEVEL : '0;
      out_data_r.frame_end <= frame_last;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

`default_nettype wire

/* hdl/bdc_checker.sv */
// Port-level checker for the dilation cascade, bound to the top level.
// Depends on bdc_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module bdc_checker import bdc_pkg::*; (
  input wire logic      clk,
  input wire logic      rst_n,
  input wire logic      in_valid,
  input wire logic      in_ready,
  input wire logic      out_valid,
  input wire logic      out_ready,
  input wire out_data_t out_data
);

  `BDC_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_data), "stalled out word changed")
  `BDC_ASSERT_IMPL(a_pix_level, clk, rst_n, out_valid, out_data.pixel_out == FG_LEVEL || out_data.pixel_out == '0, "out pixel not 0 or 255")
  `BDC_ASSERT_IMPL(a_out_cause, clk, rst_n, $rose(out_valid), $past(in_valid && in_ready), "out word without an accepted in word")
  `BDC_ASSERT_IMPL(a_in_open, clk, rst_n, !out_valid || out_ready, in_ready, "in_ready low with free out register")

endmodule

bind binary_dilation_3x3_cascade_unit bdc_checker u_bdc_checker (.*);

`default_nettype wire

/* test/binary_dilation_3x3_cascade_unit_test.sv */
// Testbench for the seven-pass binary 3x3 dilation cascade: directed frames, then random frames.
// Predicts every output word with a line-buffer model of its own; depends on bdc_pkg and the RTL.
`default_nettype none

module binary_dilation_3x3_cascade_unit_test;
  import bdc_pkg::*;

  localparam int   RING       = 2 * MAX_WIDTH + 4;
  localparam logic KIND_DRAIN = ~KIND_PIXEL;

  logic                  clk       = 1'b0;
  logic                  rst_n     = 1'b0;
  logic                  in_valid  = 1'b0;
  in_data_t              in_data   = '0;
  logic                  in_ready;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  out_data_t             out_data;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data  = '0;

  logic [WIDTH_W-1:0] width_reg  = WIDTH_W'(WIDTH_RST);
  logic [ROW_W-1:0]   height_reg = ROW_W'(HEIGHT_RST);
  bit                 line_bits [PASSES][RING];
  longint             frame_tick = 0;
  out_data_t          dilated_q[$];

  int   fail_cnt       = 0;
  int   words_sent     = 0;
  int   send_idle_pct  = 0;
  int   recv_stall_pct = 0;
  logic stall_hold     = 1'b0;
  event hold_go;

  binary_dilation_3x3_cascade_unit dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    #20_000_000;
    $display("Test completed with failures");
    $finish;
  end

  function automatic longint frame_cols();
    longint w;
    w = width_reg;
    if (w < MIN_WIDTH) w = MIN_WIDTH;
    if (w > MAX_WIDTH) w = MAX_WIDTH;
    return w;
  endfunction

  function automatic longint frame_rows();
    longint h;
    h = height_reg;
    if (h < MIN_HEIGHT) h = MIN_HEIGHT;
    return h;
  endfunction

  // OR over the interior part of the 3x3 window of pass s around raster index p
  function automatic bit window_hit(int s, longint p, longint w, longint h);
    longint y, x, ny, nx;
    int dy, dx;
    y = p / w;
    x = p % w;
    for (dy = -1; dy <= 1; dy++) begin
      for (dx = -1; dx <= 1; dx++) begin
        ny = y + dy;
        nx = x + dx;
        if (ny < 1 || ny > h - 2) continue;
        if (nx < 1 || nx > w - 2) continue;
        if (line_bits[s][(ny * w + nx) % RING]) return 1'b1;
      end
    end
    return 1'b0;
  endfunction

  function automatic void predict_dilation(in_data_t word);
    longint w, h, n, lag, q, p;
    bit v;
    int s;
    w   = frame_cols();
    h   = frame_rows();
    n   = w * h;
    lag = w + 1;
    if (word.kind != KIND_PIXEL && frame_tick < n) return;
    v = (word.kind == KIND_PIXEL && frame_tick < n && word.pixel_in == FG_LEVEL);
    q = frame_tick;
    for (s = 0; s < PASSES; s++) begin
      p = q - lag;
      if (q >= 0 && q < n) line_bits[s][q % RING] = v;
      v = (p >= 0 && p < n) ? window_hit(s, p, w, h) : 1'b0;
      q = p;
    end
    frame_tick++;
    if (q < 0 || q >= n) return;
    dilated_q.push_back('{pixel_out: v ? FG_LEVEL : 8'h00, frame_end: (q == n - 1)});
    if (q == n - 1) frame_tick = 0;
  endfunction

  function automatic logic [PIX_W-1:0] pick_pixel(int fg_pct);
    if ($urandom_range(99) < fg_pct) return FG_LEVEL;
    return PIX_W'($urandom_range(254));
  endfunction

  always @(posedge clk) begin
    out_ready <= !stall_hold && ($urandom_range(99) >= recv_stall_pct);
  end

  // long receiver hold-off, counted here while the sender keeps offering words
  initial begin
    forever begin
      @(hold_go);
      @(posedge clk);
      stall_hold <= 1'b1;
      repeat (400) @(posedge clk);
      stall_hold <= 1'b0;
    end
  end

  always @(posedge clk) begin : check_out
    out_data_t want;
    if (rst_n && out_valid && out_ready) begin
      if (dilated_q.size() == 0) begin
        $error("unexpected output word: pixel_out %0d frame_end %0d",
               out_data.pixel_out, out_data.frame_end);
        fail_cnt++;
      end else begin
        want = dilated_q.pop_front();
        if (want.pixel_out !== out_data.pixel_out) begin
          $error("pixel_out: expected %0d, actual %0d", want.pixel_out, out_data.pixel_out);
          fail_cnt++;
        end
        if (want.frame_end !== out_data.frame_end) begin
          $error("frame_end: expected %0d, actual %0d", want.frame_end, out_data.frame_end);
          fail_cnt++;
        end
      end
    end
  end

  task automatic send_word(input logic word_kind, input logic [PIX_W-1:0] pix);
    int gap;
    gap = 0;
    while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct && gap < 60) gap++;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= '{kind: word_kind, pixel_in: pix};
    do @(posedge clk); while (!in_ready);
    predict_dilation(in_data);
    words_sent++;
  endtask

  task automatic wait_results();
    int guard;
    guard = 0;
    in_valid <= 1'b0;
    while (dilated_q.size() != 0 && guard < 50000) begin
      @(posedge clk);
      guard++;
    end
    repeat (4) @(posedge clk);
    if (dilated_q.size() != 0) begin
      $error("%0d dilated pixels never arrived", dilated_q.size());
      fail_cnt++;
      dilated_q.delete();
    end
  endtask

  task automatic set_geometry(input logic [CFG_DATA_W-1:0] wval,
                              input logic [CFG_DATA_W-1:0] hval);
    cfg_valid <= 1'b1;
    cfg_index <= REG_IMAGE_WIDTH;
    cfg_data  <= wval;
    do @(posedge clk); while (!cfg_ready);
    cfg_index <= REG_IMAGE_HEIGHT;
    cfg_data  <= hval;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid  <= 1'b0;
    width_reg  = wval[WIDTH_W-1:0];
    height_reg = hval;
    frame_tick = 0;
  endtask

  // one frame in raster order plus its flush words; cut_at >= 0 stops early
  task automatic send_frame(input int fg_pct, input int cut_at);
    longint n, total, i;
    n     = frame_cols() * frame_rows();
    total = n + PASSES * (frame_cols() + 1);
    for (i = 0; i < total; i++) begin
      if (cut_at >= 0 && i >= cut_at) break;
      if (i < n) begin
        if ($urandom_range(99) < 4) send_word(KIND_DRAIN, PIX_W'($urandom));
        send_word(KIND_PIXEL, pick_pixel(fg_pct));
      end else if ($urandom_range(1) == 1) begin
        send_word(KIND_DRAIN, PIX_W'($urandom));
      end else begin
        send_word(KIND_PIXEL, PIX_W'($urandom));
      end
    end
  endtask

  task automatic test_default_geometry();
    int i;
    for (i = 0; i < 4520; i++) send_word(KIND_PIXEL, pick_pixel(2));
    wait_results();
  endtask

  task automatic test_special_cases();
    logic [PIX_W-1:0] centre_fg [9];
    logic [PIX_W-1:0] border_fg [9];
    int i;
    centre_fg = '{8'd0, 8'd255, 8'd0, 8'd254, 8'd255, 8'd1, 8'd128, 8'd255, 8'd0};
    border_fg = '{8'd255, 8'd255, 8'd255, 8'd255, 8'd254, 8'd255, 8'd255, 8'd255, 8'd255};
    set_geometry(16'd0, 16'd1);
    send_word(KIND_DRAIN, FG_LEVEL);
    for (i = 0; i < 9; i++) begin
      if (i == 8) send_word(KIND_DRAIN, 8'd0);
      send_word(KIND_PIXEL, centre_fg[i]);
    end
    for (i = 0; i < PASSES * 4; i++) send_word(i[0] ? KIND_DRAIN : KIND_PIXEL, FG_LEVEL);
    // next frame back to back: only border pixels set, so nothing survives
    for (i = 0; i < 9; i++) send_word(KIND_PIXEL, border_fg[i]);
    for (i = 0; i < PASSES * 4; i++) send_word(KIND_PIXEL, FG_LEVEL);
    wait_results();
    set_geometry(16'd2, 16'd2);
    send_frame(30, -1);
    wait_results();
    set_geometry(16'd1, 16'd0);
    send_frame(30, -1);
    wait_results();
  endtask

  task automatic test_midframe_restart();
    set_geometry(16'hF803, 16'hFFFF);
    send_frame(10, 80);
    wait_results();
    set_geometry(16'd4, 16'd3);
    send_frame(20, -1);
    wait_results();
  endtask

  task automatic test_wide_rows();
    set_geometry(16'd2047, 16'd0);
    send_frame(1, -1);
    wait_results();
  endtask

  task automatic test_backpressure();
    longint n, total, i;
    set_geometry(16'd5, 16'd40);
    n     = frame_cols() * frame_rows();
    total = n + PASSES * (frame_cols() + 1);
    for (i = 0; i < total; i++) begin
      if (i == 60) ->hold_go;
      if (i == 150) wait_results();
      send_word(i < n ? KIND_PIXEL : KIND_DRAIN, pick_pixel(5));
    end
    wait_results();
  endtask

  task automatic test_random_frames(input int send_pct, input int recv_pct);
    int start, cut, fg;
    bit restart;
    logic [CFG_DATA_W-1:0] wv, hv;
    send_idle_pct  = send_pct;
    recv_stall_pct = recv_pct;
    start   = words_sent;
    restart = 1'b1;
    while (words_sent - start < 425) begin
      if (restart || $urandom_range(2) == 0) begin
        wv = {5'($urandom), 11'($urandom_range(12))};
        if ($urandom_range(9) == 0) wv[WIDTH_W-1:0] = WIDTH_W'($urandom_range(13, 40));
        hv = 16'($urandom_range(12));
        if ($urandom_range(9) == 0) hv = 16'($urandom_range(13, 65535));
        set_geometry(wv, hv);
      end
      cut = -1;
      if (height_reg > 12 || $urandom_range(5) == 0) cut = $urandom_range(1, 150);
      case ($urandom_range(3))
        0:       fg = 0;
        1:       fg = 3;
        2:       fg = 8;
        default: fg = 25;
      endcase
      send_frame(fg, cut);
      wait_results();
      restart = (cut >= 0);
    end
    send_idle_pct  = 0;
    recv_stall_pct = 0;
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_default_geometry();
    test_special_cases();
    test_midframe_restart();
    test_wide_rows();
    test_backpressure();
    test_random_frames(0, 0);
    test_random_frames(82, 0);
    test_random_frames(0, 82);
    test_random_frames(29, 29);
    repeat (10) @(posedge clk);
    if (fail_cnt == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

`default_nettype wire
